// ----- rtl/core/u8u16_pkg.sv -----
package u8u16_pkg;

  // pending sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // bytes of the pending sequence received so far
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;
  localparam logic [1:0] HELD_THREE = 2'd3;

  // malformed lengths
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_ONE   = 2'd1;
  localparam logic [1:0] ERR_TWO   = 2'd2;
  localparam logic [1:0] ERR_THREE = 2'd3;

  // special lead bytes
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  // supplementary plane offset and surrogate prefixes
  localparam logic [19:0] SUPP_OFFSET = 20'h10000;
  localparam logic [5:0]  HI_SURR_PREFIX = 6'b110110;
  localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;

  // number of result slots in the output queue
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [15:0] unit_value;
    logic        is_error;
    logic [1:0]  error_length;
    logic        last;
  } result_t;

  // everything one byte produces
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  localparam result_t RESULT_NONE = '{unit_value: 16'h0000, is_error: 1'b0,
                                      error_length: ERR_NONE, last: 1'b0};

endpackage

// ----- rtl/core/u8u16_decode.sv -----
module u8u16_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      in_byte,
  output u8u16_pkg::step_t step
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic [7:0]  lead_held;
    logic [20:0] partial_code;
    logic [1:0]  bytes_held;
    logic [2:0]  sequence_length;
  } dec_state_t;

  typedef struct packed {
    logic       emit;
    result_t    res;
    dec_state_t st;
  } seq_start_t;

  localparam dec_state_t STATE_IDLE = '{lead_held: 8'h00, partial_code: 21'h0,
                                        bytes_held: HELD_NONE,
                                        sequence_length: SEQ_NONE};

  // decode a byte as the first byte of a new sequence
  function automatic seq_start_t begin_seq(input logic [7:0] b);
    seq_start_t s;
    s.emit = 1'b0;
    s.res  = RESULT_NONE;
    s.st   = STATE_IDLE;
    unique case (b) inside
      [8'h00:8'h7F]: begin
        s.emit = 1'b1;
        s.res.unit_value = {8'h00, b};
      end
      [8'hC2:8'hDF]: begin
        s.st.sequence_length = SEQ_TWO;
        s.st.partial_code = {16'h0, b[4:0]};
      end
      [8'hE0:8'hEF]: begin
        s.st.sequence_length = SEQ_THREE;
        s.st.partial_code = {17'h0, b[3:0]};
      end
      [8'hF0:8'hF4]: begin
        s.st.sequence_length = SEQ_FOUR;
        s.st.partial_code = {18'h0, b[2:0]};
      end
      default: begin
        s.emit = 1'b1;
        s.res.is_error = 1'b1;
        s.res.error_length = ERR_ONE;
      end
    endcase
    if (!s.emit) begin
      s.st.lead_held  = b;
      s.st.bytes_held = HELD_ONE;
    end
    return s;
  endfunction

  dec_state_t  state;
  dec_state_t  state_next;
  seq_start_t  start;
  logic        cont;
  logic [20:0] acc;
  logic [19:0] supp;
  logic        brk;
  logic [1:0]  brk_len;
  step_t       step_c;

  // one byte through the sequence rules
  always_comb begin
    cont    = (in_byte[7:6] == 2'b10);
    acc     = {state.partial_code[14:0], in_byte[5:0]};
    supp    = acc[19:0] - SUPP_OFFSET;
    start   = begin_seq(in_byte);
    brk     = 1'b0;
    brk_len = ERR_ONE;
    state_next = state;
    step_c.count  = 2'd0;
    step_c.first  = RESULT_NONE;
    step_c.second = RESULT_NONE;

    if (state.sequence_length == SEQ_TWO && state.bytes_held == HELD_ONE) begin
      if (!cont) begin
        brk = 1'b1;
      end else begin
        state_next = STATE_IDLE;
        step_c.count = 2'd1;
        step_c.first.unit_value = acc[15:0];
      end
    end else if (state.sequence_length == SEQ_THREE && state.bytes_held == HELD_ONE) begin
      // overlong three-byte form after E0
      if (!cont || (state.lead_held == LEAD_E0 && in_byte[5] == 1'b0)) begin
        brk = 1'b1;
      end else begin
        state_next.partial_code = acc;
        state_next.bytes_held = HELD_TWO;
      end
    end else if (state.sequence_length == SEQ_THREE && state.bytes_held == HELD_TWO) begin
      if (!cont) begin
        brk = 1'b1;
        brk_len = ERR_TWO;
      end else begin
        state_next = STATE_IDLE;
        step_c.count = 2'd1;
        // encoded surrogates are rejected whole
        if (acc[20:11] == 10'b0000011011) begin
          step_c.first.is_error = 1'b1;
          step_c.first.error_length = ERR_THREE;
        end else begin
          step_c.first.unit_value = acc[15:0];
        end
      end
    end else if (state.sequence_length == SEQ_FOUR && state.bytes_held == HELD_ONE) begin
      // F0 needs 90-BF, F4 needs 80-8F
      if (!cont ||
          (state.lead_held == LEAD_F0 && in_byte[5:4] == 2'b00) ||
          (state.lead_held == LEAD_F4 && in_byte[5:4] != 2'b00)) begin
        brk = 1'b1;
      end else begin
        state_next.partial_code = acc;
        state_next.bytes_held = HELD_TWO;
      end
    end else if (state.sequence_length == SEQ_FOUR && state.bytes_held == HELD_TWO) begin
      if (!cont) begin
        brk = 1'b1;
        brk_len = ERR_TWO;
      end else begin
        state_next.partial_code = acc;
        state_next.bytes_held = HELD_THREE;
      end
    end else if (state.sequence_length == SEQ_FOUR && state.bytes_held == HELD_THREE) begin
      if (!cont) begin
        brk = 1'b1;
        brk_len = ERR_THREE;
      end else begin
        state_next = STATE_IDLE;
        step_c.count = 2'd2;
        step_c.first.unit_value  = {HI_SURR_PREFIX, supp[19:10]};
        step_c.second.unit_value = {LO_SURR_PREFIX, supp[9:0]};
      end
    end else begin
      // idle, or a state no byte sequence reaches
      state_next = start.st;
      if (start.emit) begin
        step_c.count = 2'd1;
        step_c.first = start.res;
      end
    end

    // broken sequence: report it, then restart on this byte
    if (brk) begin
      state_next = start.st;
      step_c.first.unit_value = 16'h0000;
      step_c.first.is_error = 1'b1;
      step_c.first.error_length = brk_len;
      if (start.emit) begin
        step_c.count = 2'd2;
        step_c.second = start.res;
      end else begin
        step_c.count = 2'd1;
      end
    end

    // flag the final result of this byte
    if (step_c.count == 2'd2) begin
      step_c.second.last = 1'b1;
    end else if (step_c.count == 2'd1) begin
      step_c.first.last = 1'b1;
    end
  end

  assign step = step_c;

  // pending sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/u8u16_rqueue.sv -----
module u8u16_rqueue (
  input  logic                clk,
  input  logic                rst,
  input  u8u16_pkg::step_t    push,
  input  logic                push_en,
  input  logic                pop,
  output logic                room,
  output logic                not_empty,
  output logic [2:0]          level,
  output u8u16_pkg::result_t  head
);
  import u8u16_pkg::*;

  result_t     slots [QUEUE_DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [1:0]  push_n;
  logic [2:0]  level_next;

  assign push_n     = push_en ? push.count : 2'd0;
  assign level_next = level + {1'b0, push_n} - {2'b00, pop};
  // room for the two results a byte may produce
  assign room       = (level <= 3'd2);
  assign not_empty  = (level != 3'd0);
  assign head       = slots[rd_ptr];

  // result slots
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push_n == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      level  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      level  <= level_next;
    end
  end

endmodule

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 stream decoder.
// Byte channel: byte_valid / byte_stall carry in_byte, one UTF-8 byte per
// request. Result channel: result_valid / result_stall carry unit_value,
// is_error, error_length and last; a request is taken when valid is high and
// stall is low. Each byte yields zero, one or two results; last marks the
// final result of a byte, and four-byte sequences give a high then a low
// surrogate. A malformed sequence gives an error result with its length.
// An accepted byte waits in the byte register until the result queue has room,
// is then decoded into the queue, and its first result is offered at the queue head.
// Throughput: one byte per cycle while results are taken as fast; a byte that
// yields two results occupies the result port for both, which is the only
// limit since the result queue drains one result per cycle.
// The byte register is freed whenever the four-entry result queue has room
// for two results, independent of result_stall in the same cycle.
// Reset clears the pending sequence, the byte register and the result queue.
// While the receiver stalls, the queue fills and byte_stall rises once fewer
// than two slots are free; the offered result holds steady.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] unit_value,
  output logic        is_error,
  output logic [1:0]  error_length,
  output logic        last
);
  import u8u16_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       room;
  logic       advance;
  logic       accept;
  logic       pop;
  logic [2:0] level;
  step_t      step;
  result_t    head;

  assign advance    = hold_valid && room;
  assign byte_stall = hold_valid && !room;
  assign accept     = byte_valid && !byte_stall;
  assign pop        = result_valid && !result_stall;

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= in_byte;
    end
  end

  // sequence decode
  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (hold_byte),
    .step    (step)
  );

  // result queue
  u8u16_rqueue u_rqueue (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_en   (advance),
    .pop       (pop),
    .room      (room),
    .not_empty (result_valid),
    .level     (level),
    .head      (head)
  );

  assign unit_value   = head.unit_value;
  assign is_error     = head.is_error;
  assign error_length = head.error_length;
  assign last         = head.last;

  // queue level never exceeds its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= 3'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // a held byte that cannot be decoded stays held
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !room |=> hold_valid)
    else $error("held byte lost while queue full");

  // a byte giving two results leaves at least two results in the queue
  a_pair_push: assert property (@(posedge clk) disable iff (rst)
    advance && step.count == 2'd2 |=> level >= 3'd2)
    else $error("surrogate pair or split error not queued");

  // every decoded request that yields results ends with a last flag, and only there
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    advance && step.count != 2'd0 |->
      ((step.count == 2'd1 && step.first.last) ||
       (step.count == 2'd2 && step.second.last && !step.first.last)))
    else $error("last flag misplaced");

endmodule
